// ===== rtl/core/box_muller_gaussian_noise_macros.svh =====
// ----------------------------------------------------------------------------
// Box-Muller noise generator assertion macros
// Shorthand for clocked implication checks on the top level.
// ----------------------------------------------------------------------------
`ifndef BOX_MULLER_GAUSSIAN_NOISE_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_NOISE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BMG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== rtl/core/bmg_pkg.sv =====
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared types, stage counts, constants and divisor tables of the noise
// generator pipeline.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int NORM_STAGES = 5;
  localparam int LOG_STAGES  = 24;
  localparam int SQRT_STAGES = 27;
  localparam int HRN_STEPS   = 5;
  localparam int LOG_LAT     = NORM_STAGES + LOG_STAGES + 1 + SQRT_STAGES;
  localparam int PHASE_LAT   = 2 + 3 * HRN_STEPS + 1;
  localparam int PHASE_DLY   = LOG_LAT - PHASE_LAT + 1;
  localparam int PIPE_LAT    = LOG_LAT + 1;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;

  localparam logic signed [21:0] NOISE_MAX = 22'sd1048575;
  localparam logic signed [21:0] NOISE_MIN = -22'sd1048576;

  localparam logic [1:0] REG_NOISE_MEAN   = 2'd0;
  localparam logic [1:0] REG_NOISE_STDDEV = 2'd1;

  typedef struct packed {
    logic [31:0] x;
    logic [4:0]  lz;
  } norm_t;

  typedef struct packed {
    logic [31:0] m;
    logic [4:0]  lz;
    logic [23:0] f;
  } log_t;

  typedef struct packed {
    logic [53:0] v;
    logic [53:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [29:0] a;
    logic [29:0] z;
    logic [30:0] h;
    logic        use_sin;
    logic        cneg;
  } hrn_t;

  function automatic logic [6:0] hrn_div(input logic [2:0] k, input logic use_sin);
    logic [6:0] d;
    case (k)
      3'd0:    d = use_sin ? 7'd110 : 7'd90;
      3'd1:    d = use_sin ? 7'd72  : 7'd56;
      3'd2:    d = use_sin ? 7'd42  : 7'd30;
      3'd3:    d = use_sin ? 7'd20  : 7'd12;
      default: d = use_sin ? 7'd6   : 7'd2;
    endcase
    return d;
  endfunction

  // Reciprocals are floor(2^32 / d).
  function automatic logic [31:0] hrn_recip(input logic [6:0] d);
    logic [31:0] k;
    case (d)
      7'd110:  k = 32'd39045157;
      7'd90:   k = 32'd47721858;
      7'd72:   k = 32'd59652323;
      7'd56:   k = 32'd76695844;
      7'd42:   k = 32'd102261126;
      7'd30:   k = 32'd143165576;
      7'd20:   k = 32'd214748364;
      7'd12:   k = 32'd357913941;
      7'd6:    k = 32'd715827882;
      default: k = 32'd2147483648;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/bmg_norm_cell.sv =====
// ----------------------------------------------------------------------------
// bmg_norm_cell
// One step of the leading-zero normalization: shifts by a fixed power of two
// when the top bits of the word are all zero.
// ----------------------------------------------------------------------------
module bmg_norm_cell
  import bmg_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [2:0] idx,
  input  norm_t      d_i,
  output norm_t      d_o
);

  logic [4:0]  sh;
  logic [31:0] mask;
  norm_t       d_nxt;
  norm_t       d_r;

  always_comb begin
    sh    = 5'd16 >> idx;
    mask  = ~(32'hFFFF_FFFF >> sh);
    d_nxt = d_i;
    if ((d_i.x & mask) == 32'd0) begin
      d_nxt.x  = d_i.x << sh;
      d_nxt.lz = d_i.lz + sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== rtl/core/bmg_log_cell.sv =====
// ----------------------------------------------------------------------------
// bmg_log_cell
// One fraction bit of log2 of the mantissa by squaring and renormalizing.
// ----------------------------------------------------------------------------
module bmg_log_cell
  import bmg_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  log_t d_i,
  output log_t d_o
);

  logic [63:0] sq;
  logic [32:0] t;
  log_t        d_nxt;
  log_t        d_r;

  always_comb begin
    sq       = 64'(d_i.m) * 64'(d_i.m);
    t        = sq[63:31];
    d_nxt.lz = d_i.lz;
    if (t[32]) begin
      d_nxt.m = t[32:1];
      d_nxt.f = {d_i.f[22:0], 1'b1};
    end else begin
      d_nxt.m = t[31:0];
      d_nxt.f = {d_i.f[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== rtl/core/bmg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// bmg_sqrt_cell
// One result bit of the restoring integer square root.
// ----------------------------------------------------------------------------
module bmg_sqrt_cell
  import bmg_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] idx,
  input  sqrt_t      d_i,
  output sqrt_t      d_o
);

  logic [5:0]  sh;
  logic [53:0] bitv;
  logic [54:0] trial;
  sqrt_t       d_nxt;
  sqrt_t       d_r;

  always_comb begin
    sh    = 6'd52 - {idx, 1'b0};
    bitv  = 54'd1 << sh;
    trial = {1'b0, d_i.res} + {1'b0, bitv};
    if ({1'b0, d_i.v} >= trial) begin
      d_nxt.v   = d_i.v - trial[53:0];
      d_nxt.res = (d_i.res >> 1) + bitv;
    end else begin
      d_nxt.v   = d_i.v;
      d_nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== rtl/core/bmg_horner_cell.sv =====
// ----------------------------------------------------------------------------
// bmg_horner_cell
// One Horner step of the cosine or sine series: h <= 1 - (z * h) / d, over
// three stages (product, reciprocal estimate, correction).
// ----------------------------------------------------------------------------
module bmg_horner_cell
  import bmg_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [2:0] idx,
  input  hrn_t       d_i,
  output hrn_t       d_o
);

  logic [60:0] prod1;
  logic [61:0] prod2;
  logic [6:0]  div1;
  logic [6:0]  div2;
  logic [36:0] ed;
  logic [29:0] rem;
  logic [29:0] quo;
  hrn_t        s1_r;
  logic [29:0] p1_r;
  hrn_t        s2_r;
  logic [29:0] p2_r;
  logic [29:0] e2_r;
  hrn_t        s3_nxt;
  hrn_t        s3_r;

  always_comb begin
    prod1 = 61'(d_i.z) * 61'(d_i.h) + 61'h2000_0000;
    div1  = hrn_div(idx, s1_r.use_sin);
    prod2 = 62'(p1_r) * 62'(hrn_recip(div1));
    div2  = hrn_div(idx, s2_r.use_sin);
    ed    = 37'(e2_r) * 37'(div2);
    rem   = p2_r - ed[29:0];
    quo   = (rem >= 30'(div2)) ? e2_r + 30'd1 : e2_r;
    s3_nxt   = s2_r;
    s3_nxt.h = ONE_Q30 - {1'b0, quo};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= d_i;
      p1_r <= prod1[59:30];
      s2_r <= s1_r;
      p2_r <= p1_r;
      e2_r <= prod2[61:32];
      s3_r <= s3_nxt;
    end
  end

  assign d_o = s3_r;

endmodule

// ===== rtl/core/box_muller_gaussian_noise.sv =====
// ----------------------------------------------------------------------------
// box_muller_gaussian_noise
// Throughput: one item per cycle; the 27-cell square root chain and the
// 24-cell log chain set the depth. A stalled result stalls the whole chain.
// Reset: synchronous active low; clears valid bits, mean 0, stddev 1.0.
// ----------------------------------------------------------------------------
`include "box_muller_gaussian_noise_macros.svh"

module box_muller_gaussian_noise
  import bmg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_uniform_first,
  input  logic [31:0] in_uniform_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_noise_value,
  output logic [15:0] out_standard_normal,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic [29:0] a;
    logic        use_sin;
    logic        cneg;
  } phase_t;

  typedef struct packed {
    logic [30:0] c;
    logic        cneg;
  } cval_t;

  logic adv;

  logic signed [15:0] noise_mean_r;
  logic signed [15:0] noise_mean_nxt;
  logic [12:0]        noise_stddev_r;
  logic [12:0]        noise_stddev_nxt;

  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-1:0] vld_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  norm_t norm_w [NORM_STAGES+1];
  log_t  log_w  [LOG_STAGES+1];
  sqrt_t sqrt_w [SQRT_STAGES+1];
  hrn_t  hrn_w  [HRN_STEPS+1];

  logic [29:0] l_val;
  logic [61:0] r_prod;
  sqrt_t       sqrt_in_r;

  logic [31:0] vr;
  logic [1:0]  quad;
  logic [31:0] r32;
  logic        xneg;
  logic [31:0] mabs;
  logic [63:0] a_prod;
  phase_t      ph1_nxt;
  phase_t      ph1_r;
  logic [60:0] z_prod;
  hrn_t        hrn_in_r;
  logic [60:0] c_prod;
  cval_t       cval_nxt;
  cval_t       dly_r [PHASE_DLY];

  logic [58:0] n_prod;
  logic [15:0] nm_raw;
  logic [14:0] nm_r;
  logic        ncneg_r;

  logic [27:0]        sp_prod;
  logic signed [21:0] sp_s;
  logic signed [21:0] noise_sum;
  logic [15:0]        nm16;
  logic [20:0]        noise_nxt;
  logic               sat_nxt;
  logic [20:0]        out_noise_value_r;
  logic [15:0]        out_standard_normal_r;
  logic               out_saturated_r;

  logic               out_at_bound;
  logic [20:0]        mean_ext;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    noise_mean_nxt   = noise_mean_r;
    noise_stddev_nxt = noise_stddev_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOISE_MEAN:   noise_mean_nxt   = cfg_data;
        REG_NOISE_STDDEV: noise_stddev_nxt = cfg_data[12:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      vld_nxt       = {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_nxt = vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_mean_r   <= '0;
      noise_stddev_r <= 13'd256;
      vld_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      noise_mean_r   <= noise_mean_nxt;
      noise_stddev_r <= noise_stddev_nxt;
      vld_r          <= vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Logarithm and square root path.
  assign norm_w[0].x  = (in_uniform_first == 32'd0) ? 32'd1 : in_uniform_first;
  assign norm_w[0].lz = 5'd0;

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    bmg_norm_cell u_cell (
      .clk (clk),
      .en  (adv),
      .idx (3'(k)),
      .d_i (norm_w[k]),
      .d_o (norm_w[k+1])
    );
  end

  assign log_w[0].m  = norm_w[NORM_STAGES].x;
  assign log_w[0].lz = norm_w[NORM_STAGES].lz;
  assign log_w[0].f  = 24'd0;

  for (genvar k = 0; k < LOG_STAGES; k++) begin : g_log
    bmg_log_cell u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (log_w[k]),
      .d_o (log_w[k+1])
    );
  end

  always_comb begin
    l_val  = {6'(log_w[LOG_STAGES].lz) + 6'd1, 24'd0} - {6'd0, log_w[LOG_STAGES].f};
    r_prod = 62'(l_val) * 62'(LN2_Q32) + 62'h4000_0000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqrt_in_r.v   <= {r_prod[60:31], 24'd0};
      sqrt_in_r.res <= '0;
    end
  end

  assign sqrt_w[0] = sqrt_in_r;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk (clk),
      .en  (adv),
      .idx (5'(k)),
      .d_i (sqrt_w[k]),
      .d_o (sqrt_w[k+1])
    );
  end

  // Phase and cosine path.
  always_comb begin
    vr     = in_uniform_second + 32'h2000_0000;
    quad   = vr[31:30];
    r32    = in_uniform_second - {quad, 30'd0};
    xneg   = r32[31];
    mabs   = xneg ? (32'd0 - r32) : r32;
    a_prod = 64'(mabs[29:0]) * 64'(TWO_PI_Q30) + 64'h8000_0000;
    ph1_nxt.a       = a_prod[61:32];
    ph1_nxt.use_sin = quad[0];
    case (quad)
      2'd0:    ph1_nxt.cneg = 1'b0;
      2'd1:    ph1_nxt.cneg = !xneg;
      2'd2:    ph1_nxt.cneg = 1'b1;
      default: ph1_nxt.cneg = xneg;
    endcase
  end

  always_comb begin
    z_prod = 61'(ph1_r.a) * 61'(ph1_r.a) + 61'h2000_0000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph1_r            <= ph1_nxt;
      hrn_in_r.a       <= ph1_r.a;
      hrn_in_r.z       <= z_prod[59:30];
      hrn_in_r.h       <= ONE_Q30;
      hrn_in_r.use_sin <= ph1_r.use_sin;
      hrn_in_r.cneg    <= ph1_r.cneg;
    end
  end

  assign hrn_w[0] = hrn_in_r;

  for (genvar k = 0; k < HRN_STEPS; k++) begin : g_hrn
    bmg_horner_cell u_cell (
      .clk (clk),
      .en  (adv),
      .idx (3'(k)),
      .d_i (hrn_w[k]),
      .d_o (hrn_w[k+1])
    );
  end

  always_comb begin
    c_prod        = 61'(hrn_w[HRN_STEPS].a) * 61'(hrn_w[HRN_STEPS].h) + 61'h2000_0000;
    cval_nxt.c    = hrn_w[HRN_STEPS].use_sin ? {1'b0, c_prod[59:30]} : hrn_w[HRN_STEPS].h;
    cval_nxt.cneg = hrn_w[HRN_STEPS].cneg;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= cval_nxt;
      for (int i = 1; i < PHASE_DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // Combine, scale and saturate.
  always_comb begin
    n_prod = 59'(sqrt_w[SQRT_STAGES].res[26:0]) * 59'(dly_r[PHASE_DLY-1].c)
           + 59'h200_0000_0000;
    nm_raw = n_prod[57:42];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_r    <= nm_raw[15] ? 15'h7FFF : nm_raw[14:0];
      ncneg_r <= dly_r[PHASE_DLY-1].cneg;
    end
  end

  always_comb begin
    sp_prod   = 28'(noise_stddev_r) * 28'(nm_r) + 28'd2048;
    sp_s      = $signed({6'd0, sp_prod[27:12]});
    noise_sum = 22'(noise_mean_r) + (ncneg_r ? -sp_s : sp_s);
    nm16      = {1'b0, nm_r};
    sat_nxt   = 1'b0;
    noise_nxt = noise_sum[20:0];
    if (noise_sum > NOISE_MAX) begin
      noise_nxt = NOISE_MAX[20:0];
      sat_nxt   = 1'b1;
    end else if (noise_sum < NOISE_MIN) begin
      noise_nxt = NOISE_MIN[20:0];
      sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_noise_value_r     <= noise_nxt;
      out_standard_normal_r <= ncneg_r ? (16'd0 - nm16) : nm16;
      out_saturated_r       <= sat_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_noise_value     = out_noise_value_r;
  assign out_standard_normal = out_standard_normal_r;
  assign out_saturated       = out_saturated_r;

  assign out_at_bound = (out_noise_value == NOISE_MAX[20:0])
                     || (out_noise_value == NOISE_MIN[20:0]);
  assign mean_ext     = 21'(noise_mean_r);

  `BMG_ASSERT_NOW(a_sat_at_bound, out_valid && out_saturated, out_at_bound)
  `BMG_ASSERT_NOW(a_zero_gives_mean, out_valid && out_standard_normal == 16'd0, out_noise_value == mean_ext)
  `BMG_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_r))

endmodule
